@@ design/kcm_pkg.sv @@
// Package for the key chord matcher: sizes, codes and item structs.
// Used by the top level; depends on nothing.
package kcm_pkg;

  localparam int HeldSlots     = 16;
  localparam int HotkeyEntries = 16;
  localparam int CodeBits      = 10;
  localparam int KeysPerEntry  = 16;
  localparam int HeldIdxBits   = $clog2(HeldSlots);
  localparam int EntryIdxBits  = $clog2(HotkeyEntries);
  localparam int KeyIdxBits    = $clog2(KeysPerEntry);
  localparam int HotkeyDepth   = HotkeyEntries * KeysPerEntry;
  localparam int HotkeyAddrBits = $clog2(HotkeyDepth);

  localparam logic [1:0] CmdKeyEvent  = 2'd0;
  localparam logic [1:0] CmdWriteKey  = 2'd1;
  localparam logic [1:0] CmdWriteHead = 2'd2;

  localparam logic [4:0] EventKey = 5'd1;
  localparam logic [1:0] ValRelease = 2'd0;
  localparam logic [1:0] ValPress   = 2'd1;
  localparam logic [1:0] ValRepeat  = 2'd2;

  // Touchpad button codes; events carrying them are ignored.
  localparam logic [9:0] KeyToolFinger    = 10'd325;
  localparam logic [9:0] KeyTouch         = 10'd330;
  localparam logic [9:0] KeyToolDoubleTap = 10'd333;
  localparam logic [9:0] KeyToolTripleTap = 10'd334;

  localparam logic [2:0] StIgnored  = 3'd0;
  localparam logic [2:0] StAdded    = 3'd1;
  localparam logic [2:0] StHeld     = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StRemoved  = 3'd4;
  localparam logic [2:0] StNotHeld  = 3'd5;
  localparam logic [2:0] StWritten  = 3'd6;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] event_type;
    logic [1:0] event_value;
    logic [9:0] key_code;
    logic [3:0] entry;
    logic [3:0] position;
    logic [4:0] key_count;
    logic       fuzzy;
    logic       enable;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  pressed_count;
    logic        checked;
    logic [15:0] match_mask;
  } out_item_t;

endpackage

@@ design/kcm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the held set and the hotkey key words.
module kcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/key_chord_matcher.sv @@
// Top level of the key chord matcher: sequencer, held-set RAM, hotkey RAM.
// Depends on kcm_pkg and kcm_ram.
//
//   channel | ports                        | direction | payload
//   input   | in_valid/in_ready/in_item     | in        | kcm_pkg::in_item_t
//   result  | out_valid/out_ready/out_item  | out       | kcm_pkg::out_item_t
//
// One item at a time; a table write or an ignored item goes straight to the
// result. A key event searches the held-set RAM, one word per cycle; a
// release that finds its key then reads the last word and writes it into the
// freed slot. A press that grows the set then visits every hotkey entry: an
// entry that cannot match is skipped, an ordered entry compares each key word
// with the held word at the same position, and a fuzzy entry searches the
// held set for each of its key words in turn.
// Reset clears the held count and all hotkey headers; the RAMs are not
// cleared. The result sits in an output register; the next item is taken
// only once it has been delivered.
module key_chord_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kcm_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output kcm_pkg::out_item_t  out_item
);

  localparam int HB = kcm_pkg::HeldIdxBits;
  localparam int EB = kcm_pkg::EntryIdxBits;
  localparam int KB = kcm_pkg::KeyIdxBits;
  localparam int CB = kcm_pkg::CodeBits;

  // Sequencer states.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SRCH  = 10'b00_0000_0010,  // search held set for the code
    S_REL   = 10'b00_0000_0100,  // read the last entry to move it
    S_RELW  = 10'b00_0000_1000,  // write it into the freed slot
    S_ADD   = 10'b00_0001_0000,  // append the pressed code
    S_ENT   = 10'b00_0010_0000,  // start an entry
    S_ORD   = 10'b00_0100_0000,  // ordered compare, key word and held word
    S_FKEY  = 10'b00_1000_0000,  // fetch the next fuzzy key word
    S_FSCAN = 10'b01_0000_0000,  // search held set for the fuzzy key word
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  kcm_pkg::in_item_t  item_r;
  kcm_pkg::out_item_t res_r;
  logic               out_valid_r;
  logic [2:0]         st_r;         // status decided so far

  logic [HB:0]   held_count_r;
  logic [4:0]    hk_len_r   [kcm_pkg::HotkeyEntries];
  logic          hk_fuzzy_r [kcm_pkg::HotkeyEntries];
  logic          hk_valid_r [kcm_pkg::HotkeyEntries];

  logic [HB:0]   idx_r;        // held-set scan index (address issued)
  logic [HB-1:0] found_r;      // slot of found code
  logic [EB:0]   ent_r;        // hotkey entry being matched
  logic [4:0]    kpos_r;       // key position within entry
  logic [15:0]   mask_r;

  // RAM ports
  logic            held_we;
  logic [HB-1:0]   held_wa, held_ra;
  logic [CB-1:0]   held_wd, held_rd;
  logic            hk_we;
  logic [kcm_pkg::HotkeyAddrBits-1:0] hk_wa, hk_ra;
  logic [CB-1:0]   hk_rd;

  logic [CB-1:0] code;
  logic          touch_in;
  logic          accept;
  logic          key_go;
  logic [EB-1:0] ent_lo;
  logic [4:0]    cur_len;
  logic          ent_ok;
  logic          ent_end;
  logic          srch_hit;
  logic          scan_end;
  logic          set_full;
  logic          is_press;
  logic          ord_miss;
  logic          fuz_hit;
  logic [HB:0]   held_last;

  kcm_ram #(.Width(CB), .Depth(kcm_pkg::HeldSlots)) u_held (
    .clk(clk), .wr_en(held_we), .wr_addr(held_wa), .wr_data(held_wd),
    .rd_addr(held_ra), .rd_data(held_rd)
  );

  kcm_ram #(.Width(CB), .Depth(kcm_pkg::HotkeyDepth)) u_hotkey (
    .clk(clk), .wr_en(hk_we), .wr_addr(hk_wa), .wr_data(item_r.key_code[CB-1:0]),
    .rd_addr(hk_ra), .rd_data(hk_rd)
  );

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = res_r;
  assign accept    = in_valid && in_ready;

  // Only key presses and releases of non-touchpad codes need the held set.
  assign touch_in = in_item.key_code inside {kcm_pkg::KeyToolFinger, kcm_pkg::KeyTouch,
                                             kcm_pkg::KeyToolDoubleTap,
                                             kcm_pkg::KeyToolTripleTap};
  assign key_go   = (in_item.cmd == kcm_pkg::CmdKeyEvent) &&
                    (in_item.event_type == kcm_pkg::EventKey) && !touch_in &&
                    (in_item.event_value inside {kcm_pkg::ValPress, kcm_pkg::ValRelease});

  assign code     = item_r.key_code[CB-1:0];
  assign is_press = (item_r.event_value == kcm_pkg::ValPress);
  assign ent_lo   = ent_r[EB-1:0];
  assign cur_len  = hk_len_r[ent_lo];
  assign ent_end  = (ent_r == (EB+1)'(kcm_pkg::HotkeyEntries));
  // An entry can only match when its length equals the held count, which
  // also rules out zero, overlong and over-capacity lengths.
  assign ent_ok   = hk_valid_r[ent_lo] && (cur_len != 5'd0) &&
                    (cur_len <= 5'(kcm_pkg::KeysPerEntry)) &&
                    (cur_len == 5'(held_count_r));
  // During a scan held_rd holds the word at idx_r-1.
  assign srch_hit = (idx_r != '0) && (held_rd == code);
  assign fuz_hit  = (idx_r != '0) && (held_rd == hk_rd);
  assign scan_end = (idx_r == held_count_r);
  assign set_full = (held_count_r >= (HB+1)'(kcm_pkg::HeldSlots));
  assign ord_miss = (kpos_r != 5'd0) && (hk_rd != held_rd);
  assign held_last = held_count_r - 1'b1;

  // Next state and RAM port muxing.
  always_comb begin
    state_nxt = state_r;
    held_we   = 1'b0;
    held_wa   = held_count_r[HB-1:0];
    held_wd   = code;
    held_ra   = idx_r[HB-1:0];
    hk_we     = 1'b0;
    hk_wa     = {item_r.entry[EB-1:0], item_r.position[KB-1:0]};
    hk_ra     = {ent_lo, kpos_r[KB-1:0]};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = key_go ? S_SRCH : S_DONE;
        end
      end
      S_SRCH: begin
        if (srch_hit) begin
          state_nxt = is_press ? S_DONE : S_REL;
        end else if (scan_end) begin
          state_nxt = (!is_press || set_full) ? S_DONE : S_ADD;
        end
      end
      S_REL: begin
        held_ra   = held_last[HB-1:0];
        state_nxt = S_RELW;
      end
      S_RELW: begin
        held_we   = 1'b1;
        held_wa   = found_r;
        held_wd   = held_rd;
        state_nxt = S_DONE;
      end
      S_ADD: begin
        held_we   = 1'b1;
        state_nxt = S_ENT;
      end
      S_ENT: begin
        if (ent_end) begin
          state_nxt = S_DONE;
        end else if (ent_ok) begin
          state_nxt = hk_fuzzy_r[ent_lo] ? S_FKEY : S_ORD;
        end
      end
      S_ORD: begin
        held_ra = kpos_r[HB-1:0];
        if (ord_miss || kpos_r == cur_len) begin
          state_nxt = S_ENT;
        end
      end
      S_FKEY: begin
        state_nxt = (kpos_r == cur_len) ? S_ENT : S_FSCAN;
      end
      S_FSCAN: begin
        if (fuz_hit) begin
          state_nxt = S_FKEY;
        end else if (scan_end) begin
          state_nxt = S_ENT;
        end
      end
      S_DONE: begin
        hk_we     = (item_r.cmd == kcm_pkg::CmdWriteKey);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      held_count_r <= '0;
      for (int e = 0; e < kcm_pkg::HotkeyEntries; e++) begin
        hk_len_r[e]   <= '0;
        hk_fuzzy_r[e] <= 1'b0;
        hk_valid_r[e] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r <= in_item;
            idx_r  <= '0;
            mask_r <= '0;
            st_r   <= (in_item.cmd inside {kcm_pkg::CmdWriteKey, kcm_pkg::CmdWriteHead}) ?
                      kcm_pkg::StWritten : kcm_pkg::StIgnored;
          end
        end
        S_SRCH: begin
          idx_r <= idx_r + 1'b1;
          if (srch_hit) begin
            found_r <= idx_r[HB-1:0] - 1'b1;
            st_r    <= is_press ? kcm_pkg::StHeld : kcm_pkg::StRemoved;
          end else if (scan_end) begin
            if (!is_press) begin
              st_r <= kcm_pkg::StNotHeld;
            end else if (set_full) begin
              st_r <= kcm_pkg::StFull;
            end else begin
              st_r <= kcm_pkg::StAdded;
            end
          end
        end
        S_RELW: begin
          held_count_r <= held_last;
        end
        S_ADD: begin
          held_count_r <= held_count_r + 1'b1;
          ent_r        <= '0;
        end
        S_ENT: begin
          kpos_r <= '0;
          if (!ent_end && !ent_ok) begin
            ent_r <= ent_r + 1'b1;
          end
        end
        S_ORD: begin
          kpos_r <= kpos_r + 5'd1;
          if (ord_miss) begin
            ent_r <= ent_r + 1'b1;
          end else if (kpos_r == cur_len) begin
            mask_r[ent_lo] <= 1'b1;
            ent_r          <= ent_r + 1'b1;
          end
        end
        S_FKEY: begin
          idx_r <= '0;
          if (kpos_r == cur_len) begin
            mask_r[ent_lo] <= 1'b1;
            ent_r          <= ent_r + 1'b1;
          end
        end
        S_FSCAN: begin
          idx_r <= idx_r + 1'b1;
          if (fuz_hit) begin
            kpos_r <= kpos_r + 5'd1;
          end else if (scan_end) begin
            ent_r <= ent_r + 1'b1;
          end
        end
        S_DONE: begin
          out_valid_r          <= 1'b1;
          res_r.status         <= st_r;
          res_r.pressed_count  <= 5'(held_count_r);
          res_r.checked        <= (st_r == kcm_pkg::StAdded);
          res_r.match_mask     <= mask_r;
          if (item_r.cmd == kcm_pkg::CmdWriteHead) begin
            hk_len_r[item_r.entry[EB-1:0]]   <= item_r.key_count;
            hk_fuzzy_r[item_r.entry[EB-1:0]] <= item_r.fuzzy;
            hk_valid_r[item_r.entry[EB-1:0]] <= item_r.enable;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
